// ----- rtl/core/tcc_pkg.sv -----
// tcc_pkg: shared types, constants and register map for the touch
// coordinate calibrate-and-rotate block
// no dependencies
package tcc_pkg;

    localparam int SCREEN_W_DEF = 240;
    localparam int SCREEN_H_DEF = 240;

    localparam int COORD_W = 12;
    localparam int POS_W   = 16;
    localparam int REM_W   = 2 * COORD_W;
    localparam int QUO_W   = COORD_W;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    localparam logic [2:0] REG_CAL_ENABLE    = 3'd0;
    localparam logic [2:0] REG_CAL_X_LO      = 3'd1;
    localparam logic [2:0] REG_CAL_X_HI      = 3'd2;
    localparam logic [2:0] REG_CAL_Y_LO      = 3'd3;
    localparam logic [2:0] REG_CAL_Y_HI      = 3'd4;
    localparam logic [2:0] REG_QUARTER_TURNS = 3'd5;

    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    typedef struct packed {
        logic               cal_enable;
        logic [COORD_W-1:0] x_lo;
        logic [COORD_W-1:0] x_hi;
        logic [COORD_W-1:0] y_lo;
        logic [COORD_W-1:0] y_hi;
    } cal_cfg_t;

    typedef struct packed {
        logic               touched;
        logic               cal;
        logic [COORD_W-1:0] raw_x;
        logic [COORD_W-1:0] raw_y;
        logic [REM_W-1:0]   rem_x;
        logic [REM_W-1:0]   rem_y;
        logic [QUO_W-1:0]   quo_x;
        logic [QUO_W-1:0]   quo_y;
    } div_word_t;

endpackage

// ----- rtl/core/tcc_front.sv -----
// tcc_front: report decode, clamp and scale multiply, one register stage
// depends on tcc_pkg
module tcc_front
    import tcc_pkg::*;
#(
    parameter int SCREEN_W = SCREEN_W_DEF,
    parameter int SCREEN_H = SCREEN_H_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        up_valid,
    output logic        up_ready,
    input  logic        read_ok,
    input  logic [7:0]  point_count,
    input  logic [7:0]  x_high_byte,
    input  logic [7:0]  x_low_byte,
    input  logic [7:0]  y_high_byte,
    input  logic [7:0]  y_low_byte,
    input  cal_cfg_t    cfg,
    output logic        dn_valid,
    output div_word_t   dn_word,
    input  logic        dn_ready
);

    localparam logic [COORD_W-1:0] WM1 = COORD_W'(SCREEN_W - 1);
    localparam logic [COORD_W-1:0] HM1 = COORD_W'(SCREEN_H - 1);

    logic               valid_reg;
    div_word_t          word_reg;
    div_word_t          word_next;
    logic [COORD_W-1:0] raw_x;
    logic [COORD_W-1:0] raw_y;
    logic [COORD_W-1:0] clamp_x;
    logic [COORD_W-1:0] clamp_y;

    assign raw_x = {x_high_byte[3:0], x_low_byte};
    assign raw_y = {y_high_byte[3:0], y_low_byte};

    always_comb
    begin
        priority if (raw_x < cfg.x_lo)
        begin
            clamp_x = cfg.x_lo;
        end
        else if (raw_x > cfg.x_hi)
        begin
            clamp_x = cfg.x_hi;
        end
        else
        begin
            clamp_x = raw_x;
        end
        priority if (raw_y < cfg.y_lo)
        begin
            clamp_y = cfg.y_lo;
        end
        else if (raw_y > cfg.y_hi)
        begin
            clamp_y = cfg.y_hi;
        end
        else
        begin
            clamp_y = raw_y;
        end
    end

    always_comb
    begin
        word_next.touched = read_ok && (point_count != 8'd0);
        word_next.cal     = cfg.cal_enable && (cfg.x_hi > cfg.x_lo) && (cfg.y_hi > cfg.y_lo);
        word_next.raw_x   = raw_x;
        word_next.raw_y   = raw_y;
        word_next.rem_x   = REM_W'(clamp_x - cfg.x_lo) * REM_W'(WM1);
        word_next.rem_y   = REM_W'(clamp_y - cfg.y_lo) * REM_W'(HM1);
        word_next.quo_x   = '0;
        word_next.quo_y   = '0;
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            word_reg <= word_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_word  = word_reg;

endmodule

// ----- rtl/core/tcc_div_cell.sv -----
// tcc_div_cell: one restoring-divide step for both axes, one register stage
// depends on tcc_pkg
module tcc_div_cell
    import tcc_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               up_valid,
    input  div_word_t          up_word,
    output logic               up_ready,
    input  logic [COORD_W-1:0] div_x,
    input  logic [COORD_W-1:0] div_y,
    output logic               dn_valid,
    output div_word_t          dn_word,
    input  logic               dn_ready
);

    logic             valid_reg;
    div_word_t        word_reg;
    div_word_t        word_next;
    logic [REM_W-1:0] dsx;
    logic [REM_W-1:0] dsy;
    logic [QUO_W-1:0] qbit;
    logic             ge_x;
    logic             ge_y;

    assign dsx  = REM_W'(div_x) << STEP;
    assign dsy  = REM_W'(div_y) << STEP;
    assign qbit = QUO_W'(1) << STEP;
    assign ge_x = up_word.rem_x >= dsx;
    assign ge_y = up_word.rem_y >= dsy;

    always_comb
    begin
        word_next = up_word;
        if (ge_x)
        begin
            word_next.rem_x = up_word.rem_x - dsx;
            word_next.quo_x = up_word.quo_x | qbit;
        end
        if (ge_y)
        begin
            word_next.rem_y = up_word.rem_y - dsy;
            word_next.quo_y = up_word.quo_y | qbit;
        end
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            word_reg <= word_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_word  = word_reg;

endmodule

// ----- rtl/core/tcc_back.sv -----
// tcc_back: calibrated or raw select, rotation and the output register
// depends on tcc_pkg
module tcc_back
    import tcc_pkg::*;
#(
    parameter int SCREEN_W = SCREEN_W_DEF,
    parameter int SCREEN_H = SCREEN_H_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             up_valid,
    input  div_word_t        up_word,
    output logic             up_ready,
    input  logic [1:0]       quarter_turns,
    output logic             out_valid,
    input  logic             out_stall,
    output logic             touched,
    output logic [POS_W-1:0] pos_x,
    output logic [POS_W-1:0] pos_y
);

    localparam logic [POS_W-1:0] WM1 = POS_W'(SCREEN_W - 1);
    localparam logic [POS_W-1:0] HM1 = POS_W'(SCREEN_H - 1);

    logic             out_valid_reg;
    logic             touched_reg;
    logic [POS_W-1:0] pos_x_reg;
    logic [POS_W-1:0] pos_y_reg;
    logic [POS_W-1:0] sx;
    logic [POS_W-1:0] sy;
    logic [POS_W-1:0] nx;
    logic [POS_W-1:0] ny;

    always_comb
    begin
        if (up_word.cal)
        begin
            sx = POS_W'(up_word.quo_x);
            sy = POS_W'(up_word.quo_y);
        end
        else
        begin
            sx = POS_W'(up_word.raw_x);
            sy = POS_W'(up_word.raw_y);
        end
        unique case (quarter_turns)
            ROT_90:
            begin
                nx = sy;
                ny = WM1 - sx;
            end
            ROT_180:
            begin
                nx = WM1 - sx;
                ny = HM1 - sy;
            end
            ROT_270:
            begin
                nx = HM1 - sy;
                ny = sx;
            end
            default:
            begin
                nx = sx;
                ny = sy;
            end
        endcase
        if (!up_word.touched)
        begin
            nx = '0;
            ny = '0;
        end
    end

    assign up_ready = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            out_valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            touched_reg <= up_word.touched;
            pos_x_reg   <= nx;
            pos_y_reg   <= ny;
        end
    end

    assign out_valid = out_valid_reg;
    assign touched   = touched_reg;
    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;

endmodule

// ----- rtl/core/touch_coordinate_calibrate_rotate.sv -----
// touch_coordinate_calibrate_rotate: top level, register file, divide chain
// depends on tcc_pkg, tcc_front, tcc_div_cell, tcc_back
//
//  channel  handshake             payload
//  input    in_valid / in_stall   read_ok point_count x_high_byte x_low_byte
//                                 y_high_byte y_low_byte
//  output   out_valid / out_stall touched pos_x pos_y
//  config   apb write/read        cal_enable cal_x/y_lo/hi quarter_turns
//
//  one word enters per cycle unless out_stall back-pressure reaches the input;
//  stages: front multiply stage, QW divide cells, output register,
//  QW = clog2(max(SCREEN_W, SCREEN_H))
//  reset clears all valid bits and the config registers
//  a stalled output holds its word; empty stages upstream keep filling
module touch_coordinate_calibrate_rotate
    import tcc_pkg::*;
#(
    parameter int SCREEN_W = SCREEN_W_DEF,
    parameter int SCREEN_H = SCREEN_H_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              read_ok,
    input  logic [7:0]        point_count,
    input  logic [7:0]        x_high_byte,
    input  logic [7:0]        x_low_byte,
    input  logic [7:0]        y_high_byte,
    input  logic [7:0]        y_low_byte,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              touched,
    output logic [POS_W-1:0]  pos_x,
    output logic [POS_W-1:0]  pos_y
);

    localparam int SCREEN_MAX = (SCREEN_W > SCREEN_H) ? SCREEN_W : SCREEN_H;
    localparam int QW = $clog2(SCREEN_MAX);

    logic               cal_enable_reg;
    logic [COORD_W-1:0] cal_x_lo_reg;
    logic [COORD_W-1:0] cal_x_hi_reg;
    logic [COORD_W-1:0] cal_y_lo_reg;
    logic [COORD_W-1:0] cal_y_hi_reg;
    logic [1:0]         quarter_turns_reg;
    logic               wr_en;
    logic [2:0]         reg_idx;
    cal_cfg_t           cfg;
    logic [COORD_W-1:0] div_x;
    logic [COORD_W-1:0] div_y;
    logic               front_ready;

    logic               st_valid [QW+1];
    div_word_t          st_word  [QW+1];
    logic               st_ready [QW+1];

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_enable_reg    <= 1'b0;
            cal_x_lo_reg      <= '0;
            cal_x_hi_reg      <= '0;
            cal_y_lo_reg      <= '0;
            cal_y_hi_reg      <= '0;
            quarter_turns_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_CAL_ENABLE:    cal_enable_reg    <= pwdata[0];
                REG_CAL_X_LO:      cal_x_lo_reg      <= pwdata[COORD_W-1:0];
                REG_CAL_X_HI:      cal_x_hi_reg      <= pwdata[COORD_W-1:0];
                REG_CAL_Y_LO:      cal_y_lo_reg      <= pwdata[COORD_W-1:0];
                REG_CAL_Y_HI:      cal_y_hi_reg      <= pwdata[COORD_W-1:0];
                REG_QUARTER_TURNS: quarter_turns_reg <= pwdata[1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_CAL_ENABLE:    prdata = DATA_W'(cal_enable_reg);
            REG_CAL_X_LO:      prdata = DATA_W'(cal_x_lo_reg);
            REG_CAL_X_HI:      prdata = DATA_W'(cal_x_hi_reg);
            REG_CAL_Y_LO:      prdata = DATA_W'(cal_y_lo_reg);
            REG_CAL_Y_HI:      prdata = DATA_W'(cal_y_hi_reg);
            REG_QUARTER_TURNS: prdata = DATA_W'(quarter_turns_reg);
            default:           prdata = '0;
        endcase
    end

    assign cfg.cal_enable = cal_enable_reg;
    assign cfg.x_lo       = cal_x_lo_reg;
    assign cfg.x_hi       = cal_x_hi_reg;
    assign cfg.y_lo       = cal_y_lo_reg;
    assign cfg.y_hi       = cal_y_hi_reg;

    // divisors must stay fixed while words are in flight; the user is bound, the block does not enforce it
    assign div_x = cal_x_hi_reg - cal_x_lo_reg;
    assign div_y = cal_y_hi_reg - cal_y_lo_reg;

    assign in_stall = !front_ready;

    tcc_front #(
        .SCREEN_W (SCREEN_W),
        .SCREEN_H (SCREEN_H)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .up_valid    (in_valid),
        .up_ready    (front_ready),
        .read_ok     (read_ok),
        .point_count (point_count),
        .x_high_byte (x_high_byte),
        .x_low_byte  (x_low_byte),
        .y_high_byte (y_high_byte),
        .y_low_byte  (y_low_byte),
        .cfg         (cfg),
        .dn_valid    (st_valid[0]),
        .dn_word     (st_word[0]),
        .dn_ready    (st_ready[0])
    );

    // most significant quotient bit first
    for (genvar i = 0; i < QW; i++)
    begin : g_cell
        tcc_div_cell #(
            .STEP (QW - 1 - i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (st_valid[i]),
            .up_word  (st_word[i]),
            .up_ready (st_ready[i]),
            .div_x    (div_x),
            .div_y    (div_y),
            .dn_valid (st_valid[i+1]),
            .dn_word  (st_word[i+1]),
            .dn_ready (st_ready[i+1])
        );
    end

    tcc_back #(
        .SCREEN_W (SCREEN_W),
        .SCREEN_H (SCREEN_H)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .up_valid      (st_valid[QW]),
        .up_word       (st_word[QW]),
        .up_ready      (st_ready[QW]),
        .quarter_turns (quarter_turns_reg),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .touched       (touched),
        .pos_x         (pos_x),
        .pos_y         (pos_y)
    );

    a_stall_needs_full_front: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> st_valid[0])
        else $error("input stalled with an empty front stage");

    a_untouched_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !touched) |-> (pos_x == '0 && pos_y == '0))
        else $error("untouched word carries a nonzero position");

    a_quotient_x_range: assert property (@(posedge clk) disable iff (!rst_n)
        (st_valid[QW] && st_word[QW].cal) |-> (32'(st_word[QW].quo_x) < SCREEN_W))
        else $error("x quotient beyond screen width");

    a_quotient_y_range: assert property (@(posedge clk) disable iff (!rst_n)
        (st_valid[QW] && st_word[QW].cal) |-> (32'(st_word[QW].quo_y) < SCREEN_H))
        else $error("y quotient beyond screen height");

endmodule

// ----- test/tb_touch_coordinate_calibrate_rotate.sv -----
`timescale 1ns / 1ps
// tb_touch_coordinate_calibrate_rotate: self-checking bench for the touch calibrate/rotate block
// predicts each touch word from the programmed calibration and rotation, checks results in order
// depends on tcc_pkg and touch_coordinate_calibrate_rotate
module tb_touch_coordinate_calibrate_rotate;
    import tcc_pkg::*;

    localparam logic [2:0]  REG_SPARE_LO = 3'd6;
    localparam logic [2:0]  REG_SPARE_HI = 3'd7;
    localparam logic [15:0] W_LAST       = 16'(SCREEN_W_DEF - 1);
    localparam logic [15:0] H_LAST       = 16'(SCREEN_H_DEF - 1);
    localparam int          PIPE_LAT     = 12;
    localparam int          HOLD_CYCLES  = 120;
    localparam int          PHASE_WORDS  = 92;
    localparam int          MAX_PRINTS   = 40;

    typedef struct packed {
        logic       read_ok;
        logic [7:0] point_count;
        logic [7:0] x_high_byte;
        logic [7:0] x_low_byte;
        logic [7:0] y_high_byte;
        logic [7:0] y_low_byte;
    } touch_rpt_t;

    typedef struct packed {
        logic        touched;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
    } touch_pos_t;

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [ADDR_W-1:0] paddr       = '0;
    logic [DATA_W-1:0] pwdata      = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              in_valid    = 1'b0;
    logic              in_stall;
    logic              read_ok     = 1'b0;
    logic [7:0]        point_count = '0;
    logic [7:0]        x_high_byte = '0;
    logic [7:0]        x_low_byte  = '0;
    logic [7:0]        y_high_byte = '0;
    logic [7:0]        y_low_byte  = '0;
    logic              out_valid;
    logic              out_stall   = 1'b0;
    logic              touched;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;

    logic        cfg_en    = 1'b0;
    logic [11:0] cfg_x_lo  = '0;
    logic [11:0] cfg_x_hi  = '0;
    logic [11:0] cfg_y_lo  = '0;
    logic [11:0] cfg_y_hi  = '0;
    logic [1:0]  cfg_turns = ROT_0;

    touch_rpt_t report_q[$];
    touch_pos_t want_pos_q[$];
    touch_rpt_t cur_rpt;
    touch_pos_t oldest_pos;
    int         popped_cnt = 0;
    int         done_cnt   = 0;
    int         err_cnt    = 0;
    int         send_gap   = 0;
    int         stall_left = 0;
    int         hold_left  = 0;
    logic       hold_go    = 1'b0;
    logic       hold_taken = 1'b0;
    logic       quiet      = 1'b0;

    touch_coordinate_calibrate_rotate u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .read_ok     (read_ok),
        .point_count (point_count),
        .x_high_byte (x_high_byte),
        .x_low_byte  (x_low_byte),
        .y_high_byte (y_high_byte),
        .y_low_byte  (y_low_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .touched     (touched),
        .pos_x       (pos_x),
        .pos_y       (pos_y)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [15:0] fit_to_screen(logic [11:0] v, logic [11:0] lo,
                                                  logic [11:0] hi, int unsigned size);
        int unsigned c;
        c = v;
        if (c < lo)
            c = lo;
        if (c > hi)
            c = hi;
        return 16'(((c - lo) * (size - 1)) / (hi - lo));
    endfunction

    function automatic touch_pos_t map_touch(touch_rpt_t r);
        touch_pos_t  o;
        logic [15:0] ux;
        logic [15:0] uy;
        o = '0;
        if (r.read_ok && r.point_count != 8'd0)
        begin
            ux = {4'd0, r.x_high_byte[3:0], r.x_low_byte};
            uy = {4'd0, r.y_high_byte[3:0], r.y_low_byte};
            if (cfg_en && cfg_x_hi > cfg_x_lo && cfg_y_hi > cfg_y_lo)
            begin
                ux = fit_to_screen(ux[11:0], cfg_x_lo, cfg_x_hi, SCREEN_W_DEF);
                uy = fit_to_screen(uy[11:0], cfg_y_lo, cfg_y_hi, SCREEN_H_DEF);
            end
            o.touched = 1'b1;
            case (cfg_turns)
                ROT_90:
                begin
                    o.pos_x = uy;
                    o.pos_y = W_LAST - ux;
                end
                ROT_180:
                begin
                    o.pos_x = W_LAST - ux;
                    o.pos_y = H_LAST - uy;
                end
                ROT_270:
                begin
                    o.pos_x = H_LAST - uy;
                    o.pos_y = ux;
                end
                default:
                begin
                    o.pos_x = ux;
                    o.pos_y = uy;
                end
            endcase
        end
        return o;
    endfunction

    function automatic logic [11:0] pick_coord(logic [11:0] lo, logic [11:0] hi);
        case ($urandom_range(0, 7))
            0: return lo;
            1: return hi;
            2: return lo - 12'd1;
            3: return hi + 12'd1;
            4: return ($urandom_range(0, 1) != 0) ? 12'hFFF : 12'h000;
            5, 6: return 12'($urandom_range(lo, hi));
            default: return 12'($urandom);
        endcase
    endfunction

    task automatic note_mismatch(string what, logic [15:0] got, logic [15:0] want);
        if (err_cnt < MAX_PRINTS)
            $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
        err_cnt++;
    endtask

    task automatic push_report(logic ok, logic [7:0] cnt, logic [11:0] x, logic [11:0] y,
                               logic [3:0] nib);
        touch_rpt_t r;
        r.read_ok     = ok;
        r.point_count = cnt;
        r.x_high_byte = {nib, x[11:8]};
        r.x_low_byte  = x[7:0];
        r.y_high_byte = {~nib, y[11:8]};
        r.y_low_byte  = y[7:0];
        report_q.push_back(r);
    endtask

    task automatic push_random_report();
        int unsigned sel;
        logic [7:0]  cnt;
        sel = $urandom_range(0, 15);
        if (sel == 1)
            cnt = 8'd0;
        else if (sel < 5)
            cnt = 8'($urandom);
        else
            cnt = 8'd1;
        push_report(sel != 0, cnt, pick_coord(cfg_x_lo, cfg_x_hi),
                    pick_coord(cfg_y_lo, cfg_y_hi), 4'($urandom));
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_CAL_ENABLE:    cfg_en    = val[0];
            REG_CAL_X_LO:      cfg_x_lo  = val[11:0];
            REG_CAL_X_HI:      cfg_x_hi  = val[11:0];
            REG_CAL_Y_LO:      cfg_y_lo  = val[11:0];
            REG_CAL_Y_HI:      cfg_y_hi  = val[11:0];
            REG_QUARTER_TURNS: cfg_turns = val[1:0];
            default: ;
        endcase
    endtask

    // upper data bits carry junk, the block keeps only the register width
    task automatic set_cal(logic en, logic [11:0] xlo, logic [11:0] xhi, logic [11:0] ylo,
                           logic [11:0] yhi, logic [1:0] turns);
        write_reg(REG_CAL_ENABLE, {31'($urandom), en});
        write_reg(REG_CAL_X_LO, {20'($urandom), xlo});
        write_reg(REG_CAL_X_HI, {20'($urandom), xhi});
        write_reg(REG_CAL_Y_LO, {20'($urandom), ylo});
        write_reg(REG_CAL_Y_HI, {20'($urandom), yhi});
        write_reg(REG_QUARTER_TURNS, {30'($urandom), turns});
    endtask

    task automatic drain_all();
        while (report_q.size() != 0 || popped_cnt != done_cnt)
            @(posedge clk);
        repeat (PIPE_LAT)
            @(posedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                want_pos_q.push_back(map_touch(cur_rpt));
            if (!in_valid || !in_stall)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (!quiet && $urandom_range(0, 15) == 0)
                begin
                    send_gap <= $urandom_range(0, 10);
                    in_valid <= 1'b0;
                end
                else if (report_q.size() != 0)
                begin
                    cur_rpt = report_q.pop_front();
                    popped_cnt++;
                    in_valid    <= 1'b1;
                    read_ok     <= cur_rpt.read_ok;
                    point_count <= cur_rpt.point_count;
                    x_high_byte <= cur_rpt.x_high_byte;
                    x_low_byte  <= cur_rpt.x_low_byte;
                    y_high_byte <= cur_rpt.y_high_byte;
                    y_low_byte  <= cur_rpt.y_low_byte;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
            hold_left  <= 0;
            hold_taken <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (hold_go && !hold_taken)
        begin
            hold_taken <= 1'b1;
            hold_left  <= HOLD_CYCLES - 1;
            out_stall  <= 1'b1;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else if (!quiet && $urandom_range(0, 15) == 0)
        begin
            stall_left <= $urandom_range(0, 10);
            out_stall  <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (want_pos_q.size() == 0)
                note_mismatch("word with none expected", pos_x, 16'd0);
            else
            begin
                oldest_pos = want_pos_q.pop_front();
                if (touched !== oldest_pos.touched)
                    note_mismatch("touched", {15'd0, touched}, {15'd0, oldest_pos.touched});
                if (pos_x !== oldest_pos.pos_x)
                    note_mismatch("pos_x", pos_x, oldest_pos.pos_x);
                if (pos_y !== oldest_pos.pos_y)
                    note_mismatch("pos_y", pos_y, oldest_pos.pos_y);
                done_cnt++;
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        int          ph;
        logic [11:0] a;
        logic [11:0] b;
        logic [11:0] c;
        logic [11:0] d;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: no touch cases and raw extremes
        push_report(1'b0, 8'd5, 12'hFFF, 12'hFFF, 4'hF);
        push_report(1'b1, 8'd0, 12'hABC, 12'h123, 4'hF);
        push_report(1'b0, 8'd0, 12'h000, 12'h000, 4'h0);
        push_report(1'b1, 8'd1, 12'h000, 12'h000, 4'hF);
        push_report(1'b1, 8'hFF, 12'hFFF, 12'hFFF, 4'h0);
        push_report(1'b1, 8'h80, 12'hA5A, 12'h5A5, 4'hA);
        drain_all();

        // clamp below, above and at the bounds
        set_cal(1'b1, 12'd100, 12'd3900, 12'd200, 12'd3800, ROT_0);
        push_report(1'b1, 8'd1, 12'd0, 12'd4095, 4'h5);
        push_report(1'b1, 8'd1, 12'd4095, 12'd0, 4'h5);
        push_report(1'b1, 8'd1, 12'd100, 12'd200, 4'h0);
        push_report(1'b1, 8'd1, 12'd3900, 12'd3800, 4'hF);
        push_report(1'b1, 8'd1, 12'd2000, 12'd2000, 4'h3);
        drain_all();

        set_cal(1'b1, 12'd100, 12'd3900, 12'd200, 12'd3800, ROT_90);
        push_report(1'b1, 8'd1, 12'd100, 12'd3800, 4'h0);
        push_report(1'b1, 8'd1, 12'd3900, 12'd200, 4'hC);
        drain_all();

        // uncalibrated raw values past the screen wrap
        set_cal(1'b0, 12'd100, 12'd3900, 12'd200, 12'd3800, ROT_180);
        push_report(1'b1, 8'd1, 12'd0, 12'd0, 4'h0);
        push_report(1'b1, 8'd1, 12'd4095, 12'd4095, 4'hF);
        push_report(1'b1, 8'd2, 12'd239, 12'd240, 4'h6);
        drain_all();

        // spare addresses take no effect, equal bounds disable calibration
        write_reg(REG_SPARE_LO, $urandom);
        write_reg(REG_SPARE_HI, $urandom);
        set_cal(1'b1, 12'd500, 12'd500, 12'd200, 12'd3800, ROT_270);
        push_report(1'b1, 8'd1, 12'd4095, 12'd0, 4'h1);
        push_report(1'b1, 8'd1, 12'd240, 12'd239, 4'h9);
        drain_all();

        set_cal(1'b1, 12'd0, 12'd4095, 12'd0, 12'd4095, ROT_270);
        push_report(1'b1, 8'd1, 12'd4095, 12'd0, 4'h2);
        push_report(1'b1, 8'd1, 12'd1234, 12'd3210, 4'hE);

        for (ph = 0; ph < 8; ph++)
        begin
            drain_all();
            a = 12'($urandom_range(0, 4000));
            b = 12'($urandom_range(a + 1, 4095));
            c = 12'($urandom_range(0, 4000));
            d = 12'($urandom_range(c + 1, 4095));
            case (ph)
                0: set_cal(1'b1, 12'd0, 12'd4095, 12'd0, 12'd4095, ROT_0);
                1: set_cal(1'b1, 12'd4094, 12'd4095, 12'd4094, 12'd4095, ROT_90);
                2: set_cal(1'b1, a, b, c, d, ROT_180);
                3: set_cal(1'b1, a, b, c, c, ROT_270);
                4: set_cal(1'b0, a, b, c, d, 2'($urandom));
                5: set_cal(1'b1, b, a, c, d, 2'($urandom));
                default: set_cal(1'($urandom), 12'($urandom), 12'($urandom),
                                 12'($urandom), 12'($urandom), 2'($urandom));
            endcase
            if (ph == 2)
                hold_go <= 1'b1;
            if (ph == 7)
                quiet <= 1'b1;
            repeat (PHASE_WORDS)
                push_random_report();
        end

        drain_all();
        if (want_pos_q.size() != 0)
            note_mismatch("words never returned", 16'(want_pos_q.size()), 16'd0);
        if (err_cnt == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
